FILE: rtl/bbr_pkg.sv
// Shared types and constants for the streaming RGB box blur.
package bbr_pkg;

    localparam int ROW_W      = 10;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 11;
    localparam int OUT_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 8'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_DIV,
        S_OUT
    } state_t;

endpackage

FILE: rtl/bbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/box_blur_rgb_stream_top.sv
// Top level of the streaming RGB box blur.
//
// Pixels enter on s_tvalid/s_tready/s_tdata in raster order. For each center pixel whose
// (2R+1)-square window lies inside the image, one result leaves on m_tvalid/m_tready with
// the center's row and column and the truncated per-channel window mean; m_tlast marks
// the result for the bottom-right input pixel. Border pixels give no transfer.
// Configuration goes over cfg_valid/cfg_index/cfg_data (always ready): 0 radius, 1 width,
// 2 height. Any write restarts the image at row 0, column 0; write only while idle.
// Each pixel is taken in the idle state; the memory read is followed by an update step that
// writes back the column-sum and line memories. A pixel that makes no result is then done;
// one that does goes on through a reciprocal-multiply step and an output-register load.
// A result waits in the output register while m_tready is low; the next pixel is still
// taken and processed up to the point of loading its own result.
// Reset clears the position counters and control; the memories need no clearing, as
// column sums restart at row 0 and line reads only reach rows of the current image.
module box_blur_rgb_stream_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bbr_pkg::PIX_W-1:0]        s_tdata,   // red_in, green_in, blue_in
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bbr_pkg::OUT_DATA_W-1:0]   m_tdata,   // out_row, out_col, red, green, blue
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bbr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bbr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int RING   = 2 * MAX_RADIUS + 1;
    localparam int SLOT_W = $clog2(RING);
    localparam int R_W    = $clog2(MAX_RADIUS + 1);
    localparam int CS_W   = $clog2(RING * 255 + 1);
    localparam int SUM_W  = $clog2(RING * RING * 255 + 1);
    localparam int AREA_W = $clog2(RING * RING + 1);
    localparam int K      = SUM_W + AREA_W;
    localparam int RCP_W  = K + 1;
    localparam int PRD_W  = SUM_W + RCP_W;
    localparam int LS_AW  = SLOT_W + COL_W;
    localparam int LS_DEP = RING * (2 ** COL_W);
    localparam int ROW_W  = bbr_pkg::ROW_W;
    localparam int CH_W   = bbr_pkg::CH_W;

    // configuration
    logic [2:0]                      radius_reg;
    logic [bbr_pkg::CFG_DATA_W-1:0]  width_reg;
    logic [bbr_pkg::CFG_DATA_W-1:0]  height_reg;

    logic [R_W-1:0]   eff_r;
    logic [R_W:0]     twice_r;
    logic [COL_W:0]   eff_w;
    logic [10:0]      eff_h;
    logic             cfg_wr;

    always_comb
    begin
        if (32'(radius_reg) > MAX_RADIUS)
            eff_r = R_W'(MAX_RADIUS);
        else
            eff_r = R_W'(radius_reg);
        twice_r = {eff_r, 1'b0};
        if (width_reg == '0)
            eff_w = (COL_W+1)'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            eff_w = (COL_W+1)'(MAX_WIDTH);
        else
            eff_w = (COL_W+1)'(width_reg);
        if (height_reg == '0)
            eff_h = 11'd1;
        else if (32'(height_reg) > bbr_pkg::MAX_HEIGHT)
            eff_h = 11'(bbr_pkg::MAX_HEIGHT);
        else
            eff_h = height_reg;
    end

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 3'd1;
            width_reg  <= 11'd640;
            height_reg <= 11'd480;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                bbr_pkg::REG_RADIUS: radius_reg <= cfg_data[2:0];
                bbr_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                bbr_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // state machine
    bbr_pkg::state_t state_reg, state_next;
    logic in_xfer;
    logic out_free;
    logic emit_reg;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bbr_pkg::S_IDLE: if (in_xfer) state_next = bbr_pkg::S_ACC;
            bbr_pkg::S_ACC:  state_next = emit_reg ? bbr_pkg::S_DIV : bbr_pkg::S_IDLE;
            bbr_pkg::S_DIV:  state_next = bbr_pkg::S_OUT;
            bbr_pkg::S_OUT:  if (out_free) state_next = bbr_pkg::S_IDLE;
            default:         state_next = bbr_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == bbr_pkg::S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bbr_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // position
    logic [COL_W-1:0]  col_count_reg;
    logic [ROW_W-1:0]  row_count_reg;
    logic [SLOT_W-1:0] row_slot_reg;
    logic [COL_W-1:0]  col_cur;
    logic [ROW_W-1:0]  row_cur;
    logic [SLOT_W-1:0] slot_cur;
    logic [SLOT_W-1:0] slot_rd;
    int                slot_diff;

    logic [COL_W-1:0]        pcol_reg;
    logic [ROW_W-1:0]        prow_reg;
    logic [SLOT_W-1:0]       pslot_reg;
    logic [bbr_pkg::PIX_W-1:0] pix_reg;

    always_comb
    begin
        col_cur  = (32'(col_count_reg) >= 32'(eff_w)) ? '0 : col_count_reg;
        row_cur  = (32'(row_count_reg) >= 32'(eff_h)) ? '0 : row_count_reg;
        slot_cur = (32'(row_count_reg) >= 32'(eff_h)) ? '0 : row_slot_reg;
        // ring slot of the row leaving the column window
        slot_diff = 32'(slot_cur) - 32'(twice_r) - 1;
        if (slot_diff < 0)
            slot_diff = slot_diff + RING;
        slot_rd = SLOT_W'(slot_diff);
    end

    // memories
    logic [3*CS_W-1:0]          cs_rd;
    logic [3*CS_W-1:0]          cs_new;
    logic [bbr_pkg::PIX_W-1:0]  ls_rd;
    logic                       acc_we;

    assign acc_we = (state_reg == bbr_pkg::S_ACC);

    bbr_ram #(.WIDTH(3 * CS_W), .DEPTH(2 ** COL_W)) u_colsum (
        .clk   (clk),
        .we    (acc_we),
        .waddr (pcol_reg),
        .wdata (cs_new),
        .raddr (col_cur),
        .rdata (cs_rd)
    );

    bbr_ram #(.WIDTH(bbr_pkg::PIX_W), .DEPTH(LS_DEP)) u_line (
        .clk   (clk),
        .we    (acc_we),
        .waddr (LS_AW'({pslot_reg, pcol_reg})),
        .wdata (pix_reg),
        .raddr (LS_AW'({slot_rd, col_cur})),
        .rdata (ls_rd)
    );

    // column and window sums
    logic [3*CS_W-1:0]  hist_reg [RING];
    logic [3*SUM_W-1:0] win_reg;
    logic [3*SUM_W-1:0] win_new;
    logic [3*CS_W-1:0]  hist_sel;
    logic               row_full;
    logic               col_full;

    always_comb
    begin
        row_full = 32'(prow_reg) > 32'(twice_r);
        col_full = 32'(pcol_reg) > 32'(twice_r);
        hist_sel = hist_reg[SLOT_W'(twice_r)];
        for (int ch = 0; ch < 3; ch++)
        begin
            if (prow_reg == '0)
                cs_new[ch*CS_W +: CS_W] = CS_W'(pix_reg[ch*CH_W +: CH_W]);
            else if (row_full)
                cs_new[ch*CS_W +: CS_W] = cs_rd[ch*CS_W +: CS_W]
                    + CS_W'(pix_reg[ch*CH_W +: CH_W]) - CS_W'(ls_rd[ch*CH_W +: CH_W]);
            else
                cs_new[ch*CS_W +: CS_W] = cs_rd[ch*CS_W +: CS_W]
                    + CS_W'(pix_reg[ch*CH_W +: CH_W]);
            if (pcol_reg == '0)
                win_new[ch*SUM_W +: SUM_W] = SUM_W'(cs_new[ch*CS_W +: CS_W]);
            else if (col_full)
                win_new[ch*SUM_W +: SUM_W] = win_reg[ch*SUM_W +: SUM_W]
                    + SUM_W'(cs_new[ch*CS_W +: CS_W]) - SUM_W'(hist_sel[ch*CS_W +: CS_W]);
            else
                win_new[ch*SUM_W +: SUM_W] = win_reg[ch*SUM_W +: SUM_W]
                    + SUM_W'(cs_new[ch*CS_W +: CS_W]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            row_slot_reg  <= '0;
            emit_reg      <= 1'b0;
        end
        else if (cfg_wr)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            row_slot_reg  <= '0;
        end
        else if (in_xfer)
        begin
            emit_reg <= (32'(row_cur) >= 32'(twice_r)) && (32'(col_cur) >= 32'(twice_r));
            if (32'(col_cur) + 1 >= 32'(eff_w))
            begin
                col_count_reg <= '0;
                if (32'(row_cur) + 1 >= 32'(eff_h))
                begin
                    row_count_reg <= '0;
                    row_slot_reg  <= '0;
                end
                else
                begin
                    row_count_reg <= row_cur + 1'b1;
                    row_slot_reg  <= (32'(slot_cur) == RING - 1) ? '0 : slot_cur + 1'b1;
                end
            end
            else
            begin
                col_count_reg <= col_cur + 1'b1;
                row_count_reg <= row_cur;
                row_slot_reg  <= slot_cur;
            end
        end
    end

    // reciprocal table, one entry per radius
    logic [RCP_W-1:0] recip_tab [MAX_RADIUS+1];

    for (genvar g = 0; g <= MAX_RADIUS; g++)
    begin : g_rcp
        localparam int AREA = (2 * g + 1) * (2 * g + 1);
        assign recip_tab[g] = RCP_W'(((2 ** K) + AREA - 1) / AREA);
    end

    logic [ROW_W-1:0] orow_reg;
    logic [9:0]       ocol_reg;
    logic             olast_reg;
    logic [R_W-1:0]   r_reg;
    logic [PRD_W-1:0] prod_reg [3];

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pcol_reg  <= col_cur;
            prow_reg  <= row_cur;
            pslot_reg <= slot_cur;
            pix_reg   <= s_tdata;
            r_reg     <= eff_r;
            olast_reg <= (32'(row_cur) == 32'(eff_h) - 1) && (32'(col_cur) == 32'(eff_w) - 1);
        end
        if (acc_we)
        begin
            win_reg     <= win_new;
            hist_reg[0] <= cs_new;
            for (int i = 1; i < RING; i++)
                hist_reg[i] <= hist_reg[i-1];
            orow_reg <= ROW_W'(32'(prow_reg) - 32'(r_reg));
            ocol_reg <= 10'(32'(pcol_reg) - 32'(r_reg));
        end
        if (state_reg == bbr_pkg::S_DIV)
        begin
            for (int ch = 0; ch < 3; ch++)
                prod_reg[ch] <= PRD_W'(win_reg[ch*SUM_W +: SUM_W]) * PRD_W'(recip_tab[r_reg]);
        end
    end

    // output register
    logic                            m_tvalid_reg;
    logic [bbr_pkg::OUT_DATA_W-1:0]  m_tdata_reg;
    logic                            m_tlast_reg;
    logic                            out_load;

    assign out_load = (state_reg == bbr_pkg::S_OUT) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {4'd0, prod_reg[2][K +: CH_W], prod_reg[1][K +: CH_W],
                            prod_reg[0][K +: CH_W], ocol_reg, orow_reg};
            m_tlast_reg <= olast_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // checks
    a_acc_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bbr_pkg::S_ACC |-> $past(in_xfer))
        else $error("update step without an input transfer");

    a_div_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bbr_pkg::S_DIV |-> $past(state_reg) == bbr_pkg::S_ACC && $past(emit_reg))
        else $error("divide step without an interior pixel");

    a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == bbr_pkg::S_OUT)
        else $error("result raised outside the output step");

endmodule

FILE: test/tb_box_blur_rgb_stream_top.sv
// Self-checking testbench for the streaming RGB box blur top level.
`timescale 1ns / 100ps

module tb_box_blur_rgb_stream_top;

    localparam int RING_ROWS  = 15;
    localparam int LINE_LEN   = 1024;
    localparam int RADIUS_CAP = 7;
    localparam int DRAIN_WAIT = 12;
    localparam int STALL_LIMIT = 5000;

    localparam int IDLE_NONE = 0;
    localparam int IDLE_SRC  = 1;
    localparam int IDLE_SINK = 2;
    localparam int IDLE_BOTH = 3;

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } blur_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [bbr_pkg::PIX_W-1:0]      s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [bbr_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tlast;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [bbr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bbr_pkg::CFG_DATA_W-1:0] cfg_data;

    logic [bbr_pkg::PIX_W-1:0] pixel_queue[$];
    blur_result_t     blurred_queue[$];
    int               idle_mode;
    int               mismatches = 0;
    int               quiet_cycles = 0;

    // predictor state
    logic [23:0] line_mem[RING_ROWS*LINE_LEN];
    logic [2:0]  radius_reg = 3'd1;
    logic [10:0] width_reg = 11'd640;
    logic [10:0] height_reg = 11'd480;
    int          cur_row = 0;
    int          cur_col = 0;

    box_blur_rgb_stream_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int eff_radius();
        return (radius_reg > RADIUS_CAP) ? RADIUS_CAP : int'(radius_reg);
    endfunction

    function automatic int eff_width();
        if (width_reg == 0)
            return 1;
        return (width_reg > LINE_LEN) ? LINE_LEN : int'(width_reg);
    endfunction

    function automatic int eff_height();
        if (height_reg == 0)
            return 1;
        return (height_reg > bbr_pkg::MAX_HEIGHT) ? bbr_pkg::MAX_HEIGHT : int'(height_reg);
    endfunction

    task automatic apply_reg(input logic [bbr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bbr_pkg::CFG_DATA_W-1:0] val);
        if (idx == bbr_pkg::REG_RADIUS)
            radius_reg = val[2:0];
        else if (idx == bbr_pkg::REG_WIDTH)
            width_reg = val;
        else if (idx == bbr_pkg::REG_HEIGHT)
            height_reg = val;
        cur_row = 0;
        cur_col = 0;
    endtask

    task automatic blur_pixel(input logic [23:0] pix);
        int r, w, h, side, area, sr, sg, sb;
        logic [23:0] p;
        blur_result_t res;
        r = eff_radius();
        w = eff_width();
        h = eff_height();
        if (cur_col >= w)
            cur_col = 0;
        if (cur_row >= h)
            cur_row = 0;
        line_mem[(cur_row % RING_ROWS) * LINE_LEN + cur_col] = pix;
        if (cur_row >= 2*r && cur_col >= 2*r)
        begin
            side = 2*r + 1;
            area = side * side;
            sr = 0;
            sg = 0;
            sb = 0;
            for (int i = 0; i < side; i++)
                for (int j = 0; j < side; j++)
                begin
                    p = line_mem[((cur_row - 2*r + i) % RING_ROWS) * LINE_LEN
                                 + (cur_col - 2*r + j)];
                    sr += p[7:0];
                    sg += p[15:8];
                    sb += p[23:16];
                end
            res.row   = 10'(cur_row - r);
            res.col   = 10'(cur_col - r);
            res.red   = 8'(sr / area);
            res.green = 8'(sg / area);
            res.blue  = 8'(sb / area);
            res.last  = (cur_row == h-1) && (cur_col == w-1);
            blurred_queue.push_back(res);
        end
        if (cur_col + 1 >= w)
        begin
            cur_col = 0;
            cur_row = (cur_row + 1 >= h) ? 0 : cur_row + 1;
        end
        else
            cur_col = cur_col + 1;
    endtask

    function automatic bit roll(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int src_idle_pct();
        return (idle_mode == IDLE_SRC) ? 57 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    endfunction

    function automatic int sink_idle_pct();
        return (idle_mode == IDLE_SINK) ? 57 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= !roll(sink_idle_pct());
            if (!s_tvalid || s_tready)
            begin
                if (pixel_queue.size() > 0 && !roll(src_idle_pct()))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_queue.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        blur_result_t want;
        bit           moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                apply_reg(cfg_index, cfg_data);
                moved = 1'b1;
            end
            if (s_tvalid && s_tready)
            begin
                blur_pixel(s_tdata);
                moved = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                moved = 1'b1;
                if (blurred_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: data %h last %b", m_tdata, m_tlast);
                end
                else
                begin
                    want = blurred_queue.pop_front();
                    if (m_tdata[9:0] !== want.row || m_tdata[19:10] !== want.col
                        || m_tdata[27:20] !== want.red || m_tdata[35:28] !== want.green
                        || m_tdata[43:36] !== want.blue || m_tlast !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp row %0d col %0d rgb %0d %0d %0d last %b,",
                                      " got row %0d col %0d rgb %0d %0d %0d last %b"},
                                     want.row, want.col, want.red, want.green, want.blue,
                                     want.last, m_tdata[9:0], m_tdata[19:10], m_tdata[27:20],
                                     m_tdata[35:28], m_tdata[43:36], m_tlast);
                    end
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        @(posedge clk);
        while (pixel_queue.size() > 0 || s_tvalid || blurred_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bbr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bbr_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic setup_image(input int r, input int w, input int h);
        wait_drained();
        write_reg(bbr_pkg::REG_RADIUS, 11'(r));
        write_reg(bbr_pkg::REG_WIDTH, 11'(w));
        write_reg(bbr_pkg::REG_HEIGHT, 11'(h));
    endtask

    function automatic logic [23:0] random_pixel();
        case ($urandom_range(0, 9))
            0: return 24'hFFFFFF;
            1: return 24'h000000;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic push_pixels(input int n);
        for (int i = 0; i < n; i++)
            pixel_queue.push_back(random_pixel());
    endtask

    initial
    begin
        int sent, r, w, h, n, phase;
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        idle_mode    = IDLE_NONE;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: border pixels only
        push_pixels(4);
        // full-width line, oversize height clamps
        setup_image(0, 1024, 2047);
        pixel_queue.push_back(24'h000000);
        pixel_queue.push_back(24'hFFFFFF);
        pixel_queue.push_back(24'hA5C35A);
        // zero sizes behave as one pixel
        setup_image(0, 0, 0);
        push_pixels(2);
        // oversize width clamps, tall single column
        setup_image(0, 2047, 1);
        push_pixels(2);
        setup_image(0, 1, 1024);
        push_pixels(3);
        // image too small for the window
        setup_image(2, 4, 10);
        push_pixels(12);
        // writes to unused indexes still restart the frame
        setup_image(1, 3, 3);
        push_pixels(4);
        wait_drained();
        write_reg(8'd3, 11'd5);
        write_reg(8'd255, 11'h7FF);
        push_pixels(9);
        // largest window
        setup_image(7, 16, 15);
        push_pixels(240);

        sent  = 0;
        phase = 0;
        while (sent < 1100)
        begin
            r = $urandom_range(0, 3);
            w = $urandom_range(2*r + 1, 2*r + 12);
            h = $urandom_range(2*r + 1, 2*r + 8);
            if (roll(10))
                h = $urandom_range(1, 2*r + 1);
            n = w*h + $urandom_range(0, w*h);
            if (n > 300)
                n = 300;
            setup_image(r, w, h);
            idle_mode = phase % 4;
            phase++;
            push_pixels(n);
            sent += n;
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && blurred_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
